/* design/bsfc_pkg.sv */
package bsfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned SUM_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] FLETCHER_MOD = 8'd255;

    typedef enum logic [1:0] {
        SEC_IDLE   = 2'd0,
        SEC_HEADER = 2'd1,
        SEC_DATA   = 2'd2,
        SEC_SUM    = 2'd3
    } t_section;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_BAD     = 3'd3,
        KIND_FRAMING = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ESCAPE       = 3'd0,
        REG_STUFF        = 3'd1,
        REG_START_PACKET = 3'd2,
        REG_START_DATA   = 3'd3,
        REG_CHECKSUM     = 3'd4,
        REG_END_PACKET   = 3'd5
    } t_reg_index;

    localparam logic [BYTE_W-1:0] RST_ESCAPE       = 8'd165;
    localparam logic [BYTE_W-1:0] RST_STUFF        = 8'd5;
    localparam logic [BYTE_W-1:0] RST_START_PACKET = 8'd1;
    localparam logic [BYTE_W-1:0] RST_START_DATA   = 8'd2;
    localparam logic [BYTE_W-1:0] RST_CHECKSUM     = 8'd3;
    localparam logic [BYTE_W-1:0] RST_END_PACKET   = 8'd4;

    // a + b mod 255, with a below 255 and b at most 255
    function automatic logic [BYTE_W-1:0] mod_add(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FLETCHER_MOD}) begin
            s = s - {1'b0, FLETCHER_MOD};
        end
        return s[BYTE_W-1:0];
    endfunction

endpackage

/* design/byte_stuffed_frame_checker.sv */
// channel   dir  beat contents
// s (rx)    in   tdata[7:0] rx_byte
// m (res)   out  tdata[7:0] value, tdata[23:8] computed_sum; tuser[2:0] kind
// cfg       in   i_cfg_we, i_cfg_index (0..5), i_cfg_data[7:0]
//
// one byte per cycle sustained while the result side is not stalled; an accepted
// byte goes to the input register, and the section/escape/fletcher update then
// loads the result register from it when the result register can advance.
// reset is synchronous: idle section, zero sums, default codes.
// a stalled result only blocks the input once the input register is full too.
module byte_stuffed_frame_checker
    import bsfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,    // rx_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [23:0]          o_m_tdata,    // value, computed_sum
    output logic [KIND_W-1:0]    o_m_tuser,    // kind
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0] r_escape, r_stuff, r_start_packet, r_start_data;
    logic [BYTE_W-1:0] r_checksum, r_end_packet;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_section          r_section, n_section;
    logic              r_esc_pend, n_esc_pend;
    logic [BYTE_W-1:0] r_hdr_lo, n_hdr_lo, r_hdr_hi, n_hdr_hi;
    logic [BYTE_W-1:0] r_dat_lo, n_dat_lo, r_dat_hi, n_dat_hi;
    logic [SUM_W-1:0]  r_rx_sum, n_rx_sum;
    logic [1:0]        r_sum_seen, n_sum_seen;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_value;
    logic [SUM_W-1:0]  r_out_sum;

    logic              advance, proc;
    logic              emit;
    t_kind             e_kind;
    logic [BYTE_W-1:0] e_value;
    logic [SUM_W-1:0]  e_sum;
    logic              is_lit;
    logic [BYTE_W-1:0] lit_v;
    logic [BYTE_W-1:0] hdr_lo_up, hdr_hi_up, dat_lo_up, dat_hi_up;
    logic [SUM_W-1:0]  computed;

    assign advance    = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_sum, r_out_value};
    assign o_m_tuser  = r_out_kind;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape       <= RST_ESCAPE;
            r_stuff        <= RST_STUFF;
            r_start_packet <= RST_START_PACKET;
            r_start_data   <= RST_START_DATA;
            r_checksum     <= RST_CHECKSUM;
            r_end_packet   <= RST_END_PACKET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ESCAPE:       r_escape       <= i_cfg_data;
                REG_STUFF:        r_stuff        <= i_cfg_data;
                REG_START_PACKET: r_start_packet <= i_cfg_data;
                REG_START_DATA:   r_start_data   <= i_cfg_data;
                REG_CHECKSUM:     r_checksum     <= i_cfg_data;
                REG_END_PACKET:   r_end_packet   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    assign lit_v     = r_esc_pend ? r_escape : r_in_byte;
    assign is_lit    = r_esc_pend ? (r_in_byte == r_stuff) : (r_in_byte != r_escape);
    assign hdr_lo_up = mod_add(r_hdr_lo, lit_v);
    assign hdr_hi_up = mod_add(r_hdr_hi, hdr_lo_up);
    assign dat_lo_up = mod_add(r_dat_lo, lit_v);
    assign dat_hi_up = mod_add(r_dat_hi, dat_lo_up);
    assign computed  = {r_hdr_hi, r_hdr_lo} ^ {r_dat_hi, r_dat_lo};

    always_comb begin
        n_section  = r_section;
        n_esc_pend = r_esc_pend;
        n_hdr_lo   = r_hdr_lo;
        n_hdr_hi   = r_hdr_hi;
        n_dat_lo   = r_dat_lo;
        n_dat_hi   = r_dat_hi;
        n_rx_sum   = r_rx_sum;
        n_sum_seen = r_sum_seen;
        emit       = 1'b0;
        e_kind     = KIND_FRAMING;
        e_value    = '0;
        e_sum      = '0;
        if (proc) begin
            n_esc_pend = 1'b0;
            if (is_lit) begin
                case (r_section)
                    SEC_HEADER: begin
                        n_hdr_lo = hdr_lo_up;
                        n_hdr_hi = hdr_hi_up;
                        emit     = 1'b1;
                        e_kind   = KIND_HEADER;
                        e_value  = lit_v;
                    end
                    SEC_DATA: begin
                        n_dat_lo = dat_lo_up;
                        n_dat_hi = dat_hi_up;
                        emit     = 1'b1;
                        e_kind   = KIND_DATA;
                        e_value  = lit_v;
                    end
                    SEC_SUM: begin
                        if (r_sum_seen == 2'd0) begin
                            n_rx_sum   = {8'd0, lit_v};
                            n_sum_seen = 2'd1;
                        end else if (r_sum_seen == 2'd1) begin
                            n_rx_sum   = {lit_v, r_rx_sum[7:0]};
                            n_sum_seen = 2'd2;
                        end else begin
                            n_section = SEC_IDLE;
                            emit      = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else if (!r_esc_pend) begin
                n_esc_pend = 1'b1;
            end else if (r_in_byte == r_start_packet) begin
                n_section  = SEC_HEADER;
                n_hdr_lo   = '0;
                n_hdr_hi   = '0;
                n_dat_lo   = '0;
                n_dat_hi   = '0;
                n_rx_sum   = '0;
                n_sum_seen = 2'd0;
            end else if (r_section == SEC_IDLE) begin
                n_section = SEC_IDLE;
            end else if (r_in_byte == r_start_data) begin
                if (r_section != SEC_HEADER) begin
                    n_section = SEC_IDLE;
                    emit      = 1'b1;
                end else begin
                    n_section = SEC_DATA;
                end
            end else if (r_in_byte == r_checksum) begin
                if (r_section != SEC_DATA) begin
                    n_section = SEC_IDLE;
                    emit      = 1'b1;
                end else begin
                    n_section  = SEC_SUM;
                    n_sum_seen = 2'd0;
                    n_rx_sum   = '0;
                end
            end else if (r_in_byte == r_end_packet) begin
                n_section = SEC_IDLE;
                emit      = 1'b1;
                if (r_section == SEC_SUM && r_sum_seen == 2'd2) begin
                    e_kind = (computed == r_rx_sum) ? KIND_GOOD : KIND_BAD;
                    e_sum  = computed;
                end
            end else begin
                n_section = SEC_IDLE;
                emit      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section  <= SEC_IDLE;
            r_esc_pend <= 1'b0;
            r_hdr_lo   <= '0;
            r_hdr_hi   <= '0;
            r_dat_lo   <= '0;
            r_dat_hi   <= '0;
            r_rx_sum   <= '0;
            r_sum_seen <= 2'd0;
        end else begin
            r_section  <= n_section;
            r_esc_pend <= n_esc_pend;
            r_hdr_lo   <= n_hdr_lo;
            r_hdr_hi   <= n_hdr_hi;
            r_dat_lo   <= n_dat_lo;
            r_dat_hi   <= n_dat_hi;
            r_rx_sum   <= n_rx_sum;
            r_sum_seen <= n_sum_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_kind  <= e_kind;
            r_out_value <= e_value;
            r_out_sum   <= e_sum;
        end
    end

endmodule

/* tb/byte_stuffed_frame_checker_tb.sv */
`timescale 1ns / 1ps

module byte_stuffed_frame_checker_tb;
    import bsfc_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 80;
    localparam int N_REGS       = 6;
    localparam int N_PHASES     = 4;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic [SUM_W-1:0]  sum;
    } beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        bit                typed;
        bit                has_res;
        beat_t             res;
    } stim_row_t;

    localparam beat_t NO_BEAT = '{KIND_HEADER, 8'h00, 16'h0000};
    localparam beat_t FRAMING = '{KIND_FRAMING, 8'h00, 16'h0000};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_W-1:0]    i_s_tdata = '0;     // rx_byte
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [23:0]          o_m_tdata;          // value, computed_sum
    logic [KIND_W-1:0]    o_m_tuser;          // kind
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_ESCAPE;
    logic [BYTE_W-1:0]    i_cfg_data = '0;

    byte_stuffed_frame_checker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // deframer state mirror
    logic [BYTE_W-1:0] code_reg [N_REGS] = '{RST_ESCAPE, RST_STUFF, RST_START_PACKET,
                                              RST_START_DATA, RST_CHECKSUM, RST_END_PACKET};
    t_section          sec = SEC_IDLE;
    bit                esc_pending = 1'b0;
    logic [BYTE_W-1:0] hdr_lo = '0, hdr_hi = '0, dat_lo = '0, dat_hi = '0;
    logic [SUM_W-1:0]  rx_sum = '0;
    logic [1:0]        rx_sum_cnt = '0;

    beat_t     deframed_q [$];
    stim_row_t offered_bytes [$];
    int        errors = 0;
    int        bytes_sent = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;
    int        tx_calm = 0;
    int        rx_calm = 0;
    bit        held_off = 1'b0;

    // directed rows, all under the reset codes
    stim_row_t dir_rows [25] = '{
        '{8'h00,            1'b1, 1'b0, NO_BEAT},
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_START_DATA,   1'b1, 1'b0, NO_BEAT},   // escape outside a frame
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_START_PACKET, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF,            1'b1, 1'b1, '{KIND_HEADER, 8'hFF, 16'h0000}},
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_STUFF,        1'b1, 1'b1, '{KIND_HEADER, RST_ESCAPE, 16'h0000}},
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_START_DATA,   1'b1, 1'b0, NO_BEAT},
        '{8'h80,            1'b1, 1'b1, '{KIND_DATA, 8'h80, 16'h0000}},
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_CHECKSUM,     1'b1, 1'b0, NO_BEAT},
        '{8'h00,            1'b1, 1'b0, NO_BEAT},
        '{8'h00,            1'b1, 1'b0, NO_BEAT},
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_END_PACKET,   1'b0, 1'b0, NO_BEAT},   // mismatch, sum from predictor
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_START_PACKET, 1'b1, 1'b0, NO_BEAT},
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_CHECKSUM,     1'b1, 1'b1, FRAMING},   // checksum in header
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{RST_START_PACKET, 1'b1, 1'b0, NO_BEAT},
        '{RST_ESCAPE,       1'b1, 1'b0, NO_BEAT},
        '{8'hFF,            1'b1, 1'b1, FRAMING}    // unknown code
    };

    logic [BYTE_W-1:0] phase_codes [N_PHASES][N_REGS] = '{
        '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE},
        '{8'hFF, 8'h00, 8'hFF, 8'h10, 8'h20, 8'h30},
        '{8'h7E, 8'h11, 8'h22, 8'h22, 8'h33, 8'h33},   // shared codes
        '{RST_ESCAPE, RST_STUFF, RST_START_PACKET, RST_START_DATA,
          RST_CHECKSUM, RST_END_PACKET}
    };
    int phase_budget [N_PHASES] = '{80, 80, 40, 80};

    function automatic void fletcher_step(inout logic [BYTE_W-1:0] lo,
                                          inout logic [BYTE_W-1:0] hi,
                                          input logic [BYTE_W-1:0] v);
        lo = BYTE_W'((int'(lo) + int'(v)) % int'(FLETCHER_MOD));
        hi = BYTE_W'((int'(hi) + int'(lo)) % int'(FLETCHER_MOD));
    endfunction

    function automatic bit abort_frame(output beat_t res);
        sec = SEC_IDLE;
        esc_pending = 1'b0;
        res = FRAMING;
        return 1'b1;
    endfunction

    function automatic bit take_literal(input logic [BYTE_W-1:0] v, output beat_t res);
        res = NO_BEAT;
        case (sec)
            SEC_HEADER: begin
                fletcher_step(hdr_lo, hdr_hi, v);
                res = '{KIND_HEADER, v, 16'h0000};
                return 1'b1;
            end
            SEC_DATA: begin
                fletcher_step(dat_lo, dat_hi, v);
                res = '{KIND_DATA, v, 16'h0000};
                return 1'b1;
            end
            SEC_SUM: begin
                if (rx_sum_cnt == 2'd0) begin
                    rx_sum = {8'h00, v};
                    rx_sum_cnt = 2'd1;
                    return 1'b0;
                end
                if (rx_sum_cnt == 2'd1) begin
                    rx_sum[15:8] = v;
                    rx_sum_cnt = 2'd2;
                    return 1'b0;
                end
                return abort_frame(res);
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output beat_t res);
        logic [SUM_W-1:0] calc;
        res = NO_BEAT;
        if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == code_reg[REG_STUFF]) begin
                return take_literal(code_reg[REG_ESCAPE], res);
            end
            if (b == code_reg[REG_START_PACKET]) begin
                sec = SEC_HEADER;
                hdr_lo = '0;
                hdr_hi = '0;
                dat_lo = '0;
                dat_hi = '0;
                rx_sum = '0;
                rx_sum_cnt = '0;
                return 1'b0;
            end
            if (sec == SEC_IDLE) begin
                return 1'b0;
            end
            if (b == code_reg[REG_START_DATA]) begin
                if (sec != SEC_HEADER) begin
                    return abort_frame(res);
                end
                sec = SEC_DATA;
                return 1'b0;
            end
            if (b == code_reg[REG_CHECKSUM]) begin
                if (sec != SEC_DATA) begin
                    return abort_frame(res);
                end
                sec = SEC_SUM;
                rx_sum = '0;
                rx_sum_cnt = '0;
                return 1'b0;
            end
            if (b == code_reg[REG_END_PACKET]) begin
                if (sec != SEC_SUM || rx_sum_cnt != 2'd2) begin
                    return abort_frame(res);
                end
                calc = {hdr_hi, hdr_lo} ^ {dat_hi, dat_lo};
                sec = SEC_IDLE;
                res = '{(calc == rx_sum) ? KIND_GOOD : KIND_BAD, 8'h00, calc};
                return 1'b1;
            end
            return abort_frame(res);
        end
        if (b == code_reg[REG_ESCAPE]) begin
            esc_pending = 1'b1;
            return 1'b0;
        end
        return take_literal(b, res);
    endfunction

    // mostly short gaps, a few long ones, and calm stretches without any
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return code_reg[REG_ESCAPE];
        if (r < 25) return 8'h00;
        if (r < 35) return 8'hFF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send(input stim_row_t r);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= r.b;
        offered_bytes.push_back(r);
        bytes_sent++;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send('{b, 1'b0, 1'b0, NO_BEAT});
    endtask

    task automatic send_literal(input logic [BYTE_W-1:0] v);
        if (v == code_reg[REG_ESCAPE]) begin
            send_byte(code_reg[REG_ESCAPE]);
            send_byte(code_reg[REG_STUFF]);
        end else begin
            send_byte(v);
        end
    endtask

    task automatic send_code(input logic [BYTE_W-1:0] c);
        send_byte(code_reg[REG_ESCAPE]);
        send_byte(c);
    endtask

    // one frame, well formed most of the time, otherwise with one fault
    task automatic random_frame();
        logic [BYTE_W-1:0] hl, hh, dl, dh, v;
        logic [SUM_W-1:0]  sum;
        int fault, nh, nd, n_sum;
        hl = '0;
        hh = '0;
        dl = '0;
        dh = '0;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        fault = $urandom_range(0, 99);
        send_code(code_reg[REG_START_PACKET]);
        nh = $urandom_range(0, 4);
        for (int i = 0; i < nh; i++) begin
            v = pick_byte();
            fletcher_step(hl, hh, v);
            send_literal(v);
        end
        if (fault >= 85 && fault < 90) begin
            send_code(BYTE_W'($urandom_range(0, 255)));
        end
        if (fault < 70 || fault >= 75) begin
            send_code(code_reg[REG_START_DATA]);
        end
        nd = $urandom_range(0, 8);
        for (int i = 0; i < nd; i++) begin
            if (fault >= 90 && fault < 95 && i == nd / 2) begin
                send_code(code_reg[REG_START_PACKET]);
                send_code(code_reg[REG_START_DATA]);
                hl = '0;
                hh = '0;
                dl = '0;
                dh = '0;
            end
            v = pick_byte();
            fletcher_step(dl, dh, v);
            send_literal(v);
        end
        send_code(code_reg[REG_CHECKSUM]);
        sum = {hh, hl} ^ {dh, dl};
        if (fault >= 95) begin
            sum ^= SUM_W'(1 << $urandom_range(0, 15));
        end
        n_sum = 2;
        if (fault >= 75 && fault < 80) n_sum = 3;
        if (fault >= 80 && fault < 85) n_sum = $urandom_range(0, 1);
        for (int i = 0; i < n_sum; i++) begin
            if (i == 0) send_literal(sum[7:0]);
            else if (i == 1) send_literal(sum[15:8]);
            else send_literal(pick_byte());
        end
        send_code(code_reg[REG_END_PACKET]);
    endtask

    task automatic random_bytes(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            random_frame();
        end
        i_s_tvalid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (offered_bytes.size() != 0 || deframed_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_codes(input int p);
        for (int i = 0; i < N_REGS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_reg_index'(i);
            i_cfg_data  <= phase_codes[p][i];
            code_reg[i] = phase_codes[p][i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // input side: predict on each accepted beat
    always @(posedge i_clk) begin
        stim_row_t r;
        beat_t     pred;
        bit        got;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            r = offered_bytes.pop_front();
            got = deframe_byte(r.b, pred);
            if (r.typed) begin
                if (r.has_res) deframed_q.push_back(r.res);
            end else if (got) begin
                deframed_q.push_back(pred);
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        beat_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata[7:0], o_m_tdata[23:8]};
            results_seen++;
            if (deframed_q.size() == 0) begin
                $display("%0t: unexpected beat kind %0d value %0h sum %0h", $time,
                         got.kind, got.value, got.sum);
                errors++;
            end else begin
                want = deframed_q.pop_front();
                if (got.kind !== want.kind) begin
                    $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.value !== want.value) begin
                    $display("%0t: value expected %0h got %0h", $time, want.value, got.value);
                    errors++;
                end
                if (got.sum !== want.sum) begin
                    $display("%0t: sum expected %0h got %0h", $time, want.sum, got.sum);
                    errors++;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off while bytes keep coming
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held_off && results_seen >= 20) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                held_off = 1'b1;
            end
            gap = pick_gap(rx_calm);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("byte_stuffed_frame_checker test failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) begin
            send(dir_rows[i]);
        end
        random_bytes(120);
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            load_codes(p);
            random_bytes(phase_budget[p]);
        end
        settle();
        if (errors == 0 && deframed_q.size() == 0) begin
            $display("byte_stuffed_frame_checker test passed");
        end else begin
            $display("byte_stuffed_frame_checker test failed");
        end
        $finish;
    end

endmodule

/* byte_stuffed_frame_checker.f */
design/bsfc_pkg.sv
design/byte_stuffed_frame_checker.sv
tb/byte_stuffed_frame_checker_tb.sv
